FILE: rtl/paired_resource_arbiter_unit_defines.svh
// assertion macros for the paired resource arbiter unit
`ifndef PAIRED_RESOURCE_ARBITER_UNIT_DEFINES_SVH
`define PAIRED_RESOURCE_ARBITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRA_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("pra assertion failed");
`define PRA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("pra assertion failed");
`else
`define PRA_ASSERT_NOW(label, pre, post)
`define PRA_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: rtl/pra_pkg.sv
// shared types and constants of the paired resource arbiter
package pra_pkg;

   localparam int MAX_RING_DEF   = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int ID_BITS        = 5;
   localparam int TOTAL_BITS     = 16;
   localparam int CSR_BITS       = 5;

   localparam logic [CSR_BITS-1:0] RING_RESET = 5'd5;

   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic               shift;
      logic               load;
      logic [ID_BITS-1:0] load_id;
   } cell_ctrl_type;

   typedef struct packed {
      logic               valid;
      logic               slot;
      logic [ID_BITS-1:0] id;
   } grant_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [TOTAL_BITS-1:0] total;
   } result_type;

endpackage

FILE: rtl/pra_wait_cell.sv
// one cell of the wait list chain, holding one waiting requester
module pra_wait_cell #(
   parameter int INDEX    = 0,
   parameter int IDX_BITS = 4
) (
   input  logic                         clock,
   input  pra_pkg::cell_ctrl_type       ctrl,
   input  logic [IDX_BITS-1:0]          load_idx,
   input  logic [pra_pkg::ID_BITS-1:0]  neighbor_id,
   output logic [pra_pkg::ID_BITS-1:0]  cell_id
);

   logic [pra_pkg::ID_BITS-1:0] id_ff, id_in;
   logic                        hit;

   assign hit = ctrl.load && (load_idx == IDX_BITS'(INDEX));

   always_comb begin
      id_in = id_ff;
      if (hit) begin
         id_in = ctrl.load_id;
      end else if (ctrl.shift) begin
         id_in = neighbor_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign cell_id = id_ff;

endmodule

FILE: rtl/pra_count_bank.sv
// grant counters with saturating update and the two result slots
module pra_count_bank #(
   parameter int MAX_RING   = pra_pkg::MAX_RING_DEF,
   parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pra_pkg::grant_type  grant,
   output pra_pkg::result_type slot [2]
);

   localparam int IDX_BITS = $clog2(MAX_RING);
   localparam int WIDE_BITS = COUNT_BITS + pra_pkg::TOTAL_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0]          mem [MAX_RING];
   logic [MAX_RING-1:0]            written_ff, written_in;
   logic [COUNT_BITS-1:0]          rd_ff;
   logic                           hit_ff;
   logic                           pend_ff;
   logic                           slot_sel_ff;
   logic [pra_pkg::ID_BITS-1:0]    id_ff;
   logic [IDX_BITS-1:0]            idx, idx_ff;
   logic [pra_pkg::ID_BITS-1:0]    id_m1;
   logic [COUNT_BITS-1:0]          count_now, count_next;
   logic [WIDE_BITS-1:0]           wide;
   logic [pra_pkg::TOTAL_BITS-1:0] total;
   pra_pkg::result_type            slot_ff [2];

   assign id_m1 = grant.id - pra_pkg::ID_BITS'(1);
   assign idx   = IDX_BITS'(id_m1);

   always_comb begin
      written_in = written_ff;
      if (pend_ff) begin
         written_in[idx_ff] = 1'b1;
      end
   end

   assign count_now  = hit_ff ? rd_ff : '0;
   assign count_next = (count_now == COUNT_MAX) ? count_now : count_now + COUNT_BITS'(1);
   assign wide       = WIDE_BITS'(count_next);
   assign total      = (|wide[WIDE_BITS-1:pra_pkg::TOTAL_BITS]) ? '1
                                                                : wide[pra_pkg::TOTAL_BITS-1:0];

   always_ff @(posedge clock) begin
      rd_ff       <= mem[idx];
      hit_ff      <= written_ff[idx];
      idx_ff      <= idx;
      id_ff       <= grant.id;
      slot_sel_ff <= grant.slot;
      if (pend_ff) begin
         mem[idx_ff]          <= count_next;
         slot_ff[slot_sel_ff] <= '{id: id_ff, total: total};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         pend_ff    <= 1'b0;
      end else begin
         written_ff <= written_in;
         pend_ff    <= grant.valid;
      end
   end

   assign slot = slot_ff;

endmodule

FILE: rtl/paired_resource_arbiter_unit.sv
// top level of the paired resource arbiter: control, resource flags, wait list chain
//
// channel   ports                                   handshake
// input     req_kind, req_requester                 start high, busy low
// result    rsp_granted_requester, rsp_grant_total,  rsp_strobe, one cycle each
//           rsp_last
// config    csr_write_data                          csr_write_enable
//
// a request with no grant is handled in idle; one with a grant goes on through settle and emit0
// a release frees its pair and scans the whole wait list, granting up to two waiters whose pair is free,
// then goes through settle and emit states if any were granted: the wait list chain shifts one entry a cycle
// synchronous reset frees every resource, empties the wait list, clears all counts
// results leave one per cycle and are never stalled
`include "paired_resource_arbiter_unit_defines.svh"

module paired_resource_arbiter_unit #(
   parameter int MAX_RING   = pra_pkg::MAX_RING_DEF,
   parameter int COUNT_BITS = pra_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_kind,
   input  logic [pra_pkg::ID_BITS-1:0]     req_requester,
   output logic                            rsp_strobe,
   output logic [pra_pkg::ID_BITS-1:0]     rsp_granted_requester,
   output logic [pra_pkg::TOTAL_BITS-1:0]  rsp_grant_total,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [pra_pkg::CSR_BITS-1:0]    csr_write_data
);

   localparam int IDX_BITS = $clog2(MAX_RING);
   localparam int LEN_BITS = $clog2(MAX_RING + 1);
   localparam int NB = (LEN_BITS > pra_pkg::ID_BITS) ? LEN_BITS : pra_pkg::ID_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_SETTLE = 5'b00100,
      ST_EMIT0  = 5'b01000,
      ST_EMIT1  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [pra_pkg::CSR_BITS-1:0]  ring_ff;
   logic [MAX_RING-1:0]           free_ff, free_in;
   logic [MAX_RING-1:0]           waiting_ff, waiting_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [LEN_BITS-1:0]           left_ff, left_in;
   logic [LEN_BITS-1:0]           kept_ff, kept_in;
   logic [1:0]                    grants_ff, grants_in;

   logic [NB-1:0]                 ring_ext, ring_n;
   logic [NB-1:0]                 req_ext, head_ext;
   logic                          req_ok, req_pair_free;
   logic [IDX_BITS-1:0]           req_lo, req_hi, head_lo, head_hi;
   logic                          head_grantable;
   logic [LEN_BITS:0]             keep_pos;

   logic [pra_pkg::ID_BITS-1:0]   cell_id [MAX_RING];
   logic [pra_pkg::ID_BITS-1:0]   head_id;
   pra_pkg::cell_ctrl_type        cell_ctrl;
   logic [IDX_BITS-1:0]           load_idx;
   pra_pkg::grant_type            grant;
   pra_pkg::result_type           slot [2];
   logic                          emit_sel;

   assign ring_ext = NB'(ring_ff);
   assign ring_n   = (ring_ext < NB'(2)) ? NB'(2) :
                     (ring_ext > NB'(MAX_RING)) ? NB'(MAX_RING) : ring_ext;

   assign req_ext       = NB'(req_requester);
   assign req_ok        = (req_ext != '0) && (req_ext <= ring_n);
   assign req_lo        = IDX_BITS'(req_ext - NB'(1));
   assign req_hi        = (req_ext == ring_n) ? '0 : IDX_BITS'(req_ext);
   assign req_pair_free = free_ff[req_lo] && free_ff[req_hi];

   assign head_id        = cell_id[0];
   assign head_ext       = NB'(head_id);
   assign head_lo        = IDX_BITS'(head_ext - NB'(1));
   assign head_hi        = (head_ext == ring_n) ? '0 : IDX_BITS'(head_ext);
   assign head_grantable = (grants_ff != 2'd2) && (head_ext != '0) && (head_ext <= ring_n)
                           && free_ff[head_lo] && free_ff[head_hi];

   assign keep_pos = (LEN_BITS + 1)'(left_ff) + (LEN_BITS + 1)'(kept_ff)
                     - (LEN_BITS + 1)'(1);

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      free_in    = free_ff;
      waiting_in = waiting_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      kept_in    = kept_ff;
      grants_in  = grants_ff;
      grant      = '0;
      cell_ctrl  = '0;
      load_idx   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_ok) begin
               if (req_kind == pra_pkg::KIND_REQUEST) begin
                  if (!waiting_ff[req_lo]) begin
                     if (req_pair_free) begin
                        free_in[req_lo] = 1'b0;
                        free_in[req_hi] = 1'b0;
                        grant.valid     = 1'b1;
                        grant.slot      = 1'b0;
                        grant.id        = req_requester;
                        grants_in       = 2'd1;
                        state_in        = ST_SETTLE;
                     end else if (len_ff < LEN_BITS'(MAX_RING)) begin
                        cell_ctrl.load     = 1'b1;
                        cell_ctrl.load_id  = req_requester;
                        load_idx           = IDX_BITS'(len_ff);
                        len_in             = len_ff + LEN_BITS'(1);
                        waiting_in[req_lo] = 1'b1;
                     end
                  end
               end else begin
                  free_in[req_lo] = 1'b1;
                  free_in[req_hi] = 1'b1;
                  left_in         = len_ff;
                  kept_in         = '0;
                  grants_in       = '0;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               len_in   = kept_ff;
               state_in = (grants_ff != 2'd0) ? ST_SETTLE : ST_IDLE;
            end else begin
               cell_ctrl.shift = 1'b1;
               left_in         = left_ff - LEN_BITS'(1);
               if (head_grantable) begin
                  free_in[head_lo]    = 1'b0;
                  free_in[head_hi]    = 1'b0;
                  waiting_in[head_lo] = 1'b0;
                  grant.valid         = 1'b1;
                  grant.slot          = grants_ff[0];
                  grant.id            = head_id;
                  grants_in           = grants_ff + 2'd1;
               end else begin
                  cell_ctrl.load    = 1'b1;
                  cell_ctrl.load_id = head_id;
                  load_idx          = keep_pos[IDX_BITS-1:0];
                  kept_in           = kept_ff + LEN_BITS'(1);
               end
            end
         end
         ST_SETTLE: begin
            state_in = ST_EMIT0;
         end
         ST_EMIT0: begin
            state_in = (grants_ff == 2'd2) ? ST_EMIT1 : ST_IDLE;
         end
         ST_EMIT1: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ring_ff    <= pra_pkg::RING_RESET;
         free_ff    <= '1;
         waiting_ff <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         kept_ff    <= '0;
         grants_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         free_ff    <= free_in;
         waiting_ff <= waiting_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
         kept_ff    <= kept_in;
         grants_ff  <= grants_in;
         if (csr_write_enable) begin
            ring_ff <= csr_write_data;
         end
      end
   end

   // wait list chain, oldest entry in cell zero
   for (genvar g = 0; g < MAX_RING; g++) begin : g_cell
      logic [pra_pkg::ID_BITS-1:0] neighbor_id;
      if (g == MAX_RING - 1) begin : g_end
         assign neighbor_id = cell_id[g];
      end else begin : g_mid
         assign neighbor_id = cell_id[g+1];
      end
      pra_wait_cell #(
         .INDEX    (g),
         .IDX_BITS (IDX_BITS)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .load_idx    (load_idx),
         .neighbor_id (neighbor_id),
         .cell_id     (cell_id[g])
      );
   end

   pra_count_bank #(
      .MAX_RING   (MAX_RING),
      .COUNT_BITS (COUNT_BITS)
   ) u_count_bank (
      .clock (clock),
      .reset (reset),
      .grant (grant),
      .slot  (slot)
   );

   assign emit_sel              = (state_ff == ST_EMIT1);
   assign rsp_strobe            = (state_ff == ST_EMIT0) || (state_ff == ST_EMIT1);
   assign rsp_granted_requester = slot[emit_sel].id;
   assign rsp_grant_total       = slot[emit_sel].total;
   assign rsp_last              = rsp_strobe && (emit_sel || (grants_ff != 2'd2));

   `PRA_ASSERT_NOW(a_strobe_while_busy, rsp_strobe, busy)
   `PRA_ASSERT_NEXT(a_first_of_two_then_last, rsp_strobe && !rsp_last, rsp_strobe && rsp_last)
   `PRA_ASSERT_NEXT(a_release_starts_scan, start && !busy && req_ok && req_kind, state_ff == ST_SCAN)
   `PRA_ASSERT_NOW(a_waiting_matches_length, state_ff == ST_IDLE, $countones(waiting_ff) == int'(len_ff))

endmodule
